// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define RMW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// antecedent this cycle implies consequent next cycle
`define RMW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define RMW_ASSERT(name, clk, rst_n, prop)
`define RMW_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: src/rmw_pkg.sv
// ---------------------------------------------------------------------------
// rmw_pkg
// Shared types, constants and the sine table of the ring modulator
// ---------------------------------------------------------------------------
package rmw_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PHASE_W    = IDX_W + FRAC_BITS;
  localparam int STEP_W     = 24;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = SMP_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RND_SHIFT  = 27;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_OSC    = 2'd1,
    MODE_EXT    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_STEP = 2'd1,
    CFG_GAIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_SG   = 2'd1,
    MUL_INT  = 2'd2,
    MUL_MOD  = 2'd3
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    mul_sel_e mul_sel;
    logic     ld_rom;
    logic     ld_p1;
    logic     ld_v;
    logic     ld_p2;
    logic     ld_out;
  } rmw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic osc;
  } rmw_sts_t;

  typedef logic signed [SMP_W-1:0] sine_rom_t [0:TABLE_SIZE-1];

  // quarter-wave sine in Q15, taylor series with truncating Q30 steps
  function automatic logic signed [SMP_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    x    = (HALF_PI_Q30 * r) / 64'(TABLE_SIZE);
    term = x;
    sum  = x;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return SMP_W'(q);
  endfunction

  // full-wave table folded from the quarter wave
  function automatic sine_rom_t build_rom();
    sine_rom_t            rom;
    int                   p;
    int                   quad;
    int                   r;
    logic signed [SMP_W-1:0] v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      p    = i * 4;
      quad = (p / TABLE_SIZE) % 4;
      r    = p % TABLE_SIZE;
      if (quad[0]) begin
        v = quarter_sine(64'(TABLE_SIZE - r));
      end else begin
        v = quarter_sine(64'(r));
      end
      rom[i] = quad[1] ? -v : v;
    end
    return rom;
  endfunction

  // entry TABLE_SIZE equals entry 0, so the upper tap wraps the index
  localparam sine_rom_t SINE_ROM = build_rom();

endpackage

// File: src/rmw_ctrl.sv
// ---------------------------------------------------------------------------
// rmw_ctrl
// Sequencer: steps one item through the shared multiplier, owns output valid
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rmw_pkg::rmw_sts_t sts_i,
  output rmw_pkg::rmw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SG,
    ST_INT,
    ST_MOD,
    ST_ROUND
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.mul_sel  = rmw_pkg::MUL_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SG;
        end
      end
      ST_SG: begin
        // table read and sample*gain share this cycle
        cmd_o.mul_sel = rmw_pkg::MUL_SG;
        cmd_o.ld_rom  = 1'b1;
        cmd_o.ld_p1   = 1'b1;
        state_d       = sts_i.osc ? ST_INT : ST_MOD;
      end
      ST_INT: begin
        cmd_o.mul_sel = rmw_pkg::MUL_INT;
        cmd_o.ld_v    = 1'b1;
        state_d       = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mul_sel = rmw_pkg::MUL_MOD;
        cmd_o.ld_p2   = 1'b1;
        state_d       = ST_ROUND;
      end
      ST_ROUND: begin
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `RMW_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `RMW_ASSERT(a_rise_from_round, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == ST_ROUND))
  `RMW_ASSERT(a_interp_osc_only, clk_i, rst_ni, (state_q == ST_INT) |-> sts_i.osc)
  `RMW_ASSERT_NEXT(a_round_done, clk_i, rst_ni, (state_q == ST_ROUND) && out_free,
                   out_valid_q && (state_q == ST_IDLE))

endmodule

// File: src/rmw_dp.sv
// ---------------------------------------------------------------------------
// rmw_dp
// Datapath: config registers, phase accumulator, sine table, shared multiplier
// ---------------------------------------------------------------------------
module rmw_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rmw_pkg::rmw_cmd_t                      cmd_i,
  output rmw_pkg::rmw_sts_t                      sts_o,
  input  logic                                   cfg_we_i,
  input  logic [rmw_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [rmw_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [rmw_pkg::SMP_W-1:0]       sample_i,
  input  logic signed [rmw_pkg::SMP_W-1:0]       mod_sample_i,
  input  logic                                   block_end_i,
  output logic signed [rmw_pkg::SMP_W-1:0]       out_sample_o,
  output logic                                   block_end_out_o
);

  localparam int SMP_W   = rmw_pkg::SMP_W;
  localparam int PROD_W  = rmw_pkg::PROD_W;
  localparam int IDX_W   = rmw_pkg::IDX_W;
  localparam int PHASE_W = rmw_pkg::PHASE_W;
  localparam int FRAC_W  = rmw_pkg::FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (rmw_pkg::RND_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN  = -PROD_W'(32768);

  // configuration
  logic [1:0]                         mode_q;
  logic [rmw_pkg::STEP_W-1:0]         step_q;
  logic signed [rmw_pkg::GAIN_W-1:0]  gain_q;

  // item state
  logic [PHASE_W-1:0]                 phase_q;
  logic signed [SMP_W-1:0]            sample_q;
  logic signed [SMP_W-1:0]            mod_q;
  logic                               blk_q;
  logic signed [SMP_W-1:0]            a_q;
  logic signed [SMP_W:0]              diff_q;
  logic signed [SMP_W-1:0]            v_q;
  logic signed [rmw_pkg::MUL_A_W-1:0] p1_q;
  logic signed [PROD_W-1:0]           p2_q;
  logic signed [SMP_W-1:0]            out_q;
  logic                               blk_out_q;

  logic [IDX_W-1:0]                   idx;
  logic [IDX_W-1:0]                   idx_nx;
  logic [FRAC_W-1:0]                  frac;
  logic signed [SMP_W-1:0]            rom_a;
  logic signed [SMP_W-1:0]            rom_b;
  logic signed [SMP_W:0]              diff_d;
  logic signed [SMP_W-1:0]            m_sel;
  logic signed [rmw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [rmw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]           prod;
  logic signed [PROD_W-1:0]           interp;
  logic signed [SMP_W-1:0]            v_d;
  logic signed [PROD_W-1:0]           rnd;
  logic signed [SMP_W-1:0]            sat_d;

  assign sts_o.osc = (mode_q == rmw_pkg::MODE_OSC);

  assign idx    = phase_q[PHASE_W-1:FRAC_W];
  assign idx_nx = idx + IDX_W'(1);
  assign frac   = phase_q[FRAC_W-1:0];
  assign rom_a  = rmw_pkg::SINE_ROM[idx];
  assign rom_b  = rmw_pkg::SINE_ROM[idx_nx];
  assign diff_d = {rom_b[SMP_W-1], rom_b} - {rom_a[SMP_W-1], rom_a};

  always_comb begin
    case (mode_q)
      rmw_pkg::MODE_OSC: m_sel = v_q;
      rmw_pkg::MODE_EXT: m_sel = mod_q;
      default:           m_sel = '0;
    endcase
  end

  // single shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      rmw_pkg::MUL_SG: begin
        mul_a = rmw_pkg::MUL_A_W'(sample_q);
        mul_b = rmw_pkg::MUL_B_W'(gain_q);
      end
      rmw_pkg::MUL_INT: begin
        mul_a = rmw_pkg::MUL_A_W'(diff_q);
        mul_b = signed'({1'b0, frac});
      end
      rmw_pkg::MUL_MOD: begin
        mul_a = p1_q;
        mul_b = rmw_pkg::MUL_B_W'(m_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign interp = prod >>> FRAC_W;
  assign v_d    = a_q + interp[SMP_W-1:0];

  // round half up to Q15, then saturate
  always_comb begin
    rnd = (p2_q + RND_HALF) >>> rmw_pkg::RND_SHIFT;
    if (rnd > SAT_MAX) begin
      sat_d = 16'sh7fff;
    end else if (rnd < SAT_MIN) begin
      sat_d = -16'sh8000;
    end else begin
      sat_d = rnd[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rmw_pkg::MODE_SILENT;
      step_q  <= '0;
      gain_q  <= rmw_pkg::GAIN_RESET;
      phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rmw_pkg::CFG_MODE: mode_q <= cfg_data_i[1:0];
          rmw_pkg::CFG_STEP: step_q <= cfg_data_i[rmw_pkg::STEP_W-1:0];
          rmw_pkg::CFG_GAIN: gain_q <= cfg_data_i[rmw_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      // phase advances before lookup, only in oscillator mode
      if (cmd_i.accept && sts_o.osc) begin
        phase_q <= phase_q + step_q[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      mod_q    <= mod_sample_i;
      blk_q    <= block_end_i;
    end
    if (cmd_i.ld_rom) begin
      a_q    <= rom_a;
      diff_q <= diff_d;
    end
    if (cmd_i.ld_p1) begin
      p1_q <= prod[rmw_pkg::MUL_A_W-1:0];
    end
    if (cmd_i.ld_v) begin
      v_q <= v_d;
    end
    if (cmd_i.ld_p2) begin
      p2_q <= prod;
    end
    if (cmd_i.ld_out) begin
      out_q     <= sat_d;
      blk_out_q <= blk_q;
    end
  end

  assign out_sample_o    = out_q;
  assign block_end_out_o = blk_out_q;

endmodule

// File: src/ring_modulator_wavetable.sv
// ---------------------------------------------------------------------------
// ring_modulator_wavetable
// Ring modulator with interpolated wavetable sine oscillator or external
// modulator, gain in Q4.12, saturated Q1.15 output
// ---------------------------------------------------------------------------
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o   | sample_i, mod_sample_i, block_end_i
//   out     | out_valid_o / out_stall_i | out_sample_o, block_end_out_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// items are taken one at a time, the next only after rounding; the steps are: accept,
// sample*gain with table read, interpolation (oscillator only), modulator product, rounding
// the products share one 32x17 multiplier; the result is in the output register
// once the rounding step completes
// a stalled result holds the output register, the next item waits in its rounding step
// reset clears the phase, selects silent mode, zero step and unity gain; cfg_ready_o is high

module ring_modulator_wavetable (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [rmw_pkg::SMP_W-1:0]       sample_i,
  input  logic signed [rmw_pkg::SMP_W-1:0]       mod_sample_i,
  input  logic                                   block_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [rmw_pkg::SMP_W-1:0]       out_sample_o,
  output logic                                   block_end_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rmw_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [rmw_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  rmw_pkg::rmw_cmd_t cmd;
  rmw_pkg::rmw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .mod_sample_i    (mod_sample_i),
    .block_end_i     (block_end_i),
    .out_sample_o    (out_sample_o),
    .block_end_out_o (block_end_out_o)
  );

endmodule
